[rtl/core/stq_pkg.sv]
// Shared types and constants for the sorted timeout queue.
// Used by the cell, the cell chain and the top level; no dependencies.
package stq_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SLOT_W  = 5;
   localparam int KEY_W   = 32;
   localparam int TICK_W  = 32;

   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_ARM         = 3'd1;
   localparam logic [2:0] OP_CANCEL_KEY  = 3'd2;
   localparam logic [2:0] OP_CANCEL_SLOT = 3'd3;
   localparam logic [2:0] OP_EXPIRE      = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_NOT_DUE   = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TICK_W-1:0] deadline;
      logic [KEY_W-1:0]  func;
      logic [KEY_W-1:0]  arg;
   } payload_type;

   typedef struct packed {
      logic        valid;
      payload_type data;
   } entry_type;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [IDX_W-1:0] pos;
   } chain_cmd_type;

endpackage

[rtl/core/stq_cell.sv]
// One queue position of the sorted timeout queue.
// Depends on stq_pkg; holds one entry and trades it with its neighbors.
module stq_cell
   import stq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  chain_cmd_type    cmd,
   input  entry_type        new_entry,
   input  entry_type        left_entry,
   input  logic             left_ge,
   input  entry_type        right_entry,
   output entry_type        entry_out,
   output logic             ge_out
);

   logic        valid_ff, valid_in;
   payload_type data_ff, data_in;
   entry_type   next_entry;

   // Entries are sorted, so the cells at or after the insert point form a suffix.
   assign ge_out = !valid_ff || (data_ff.deadline >= new_entry.data.deadline);

   always_comb begin
      next_entry = '{valid: valid_ff, data: data_ff};
      priority if (cmd.insert && ge_out) begin
         next_entry = left_ge ? left_entry : new_entry;
      end else if (cmd.remove && (cell_idx >= cmd.pos)) begin
         next_entry = right_entry;
      end
      valid_in = next_entry.valid;
      data_in  = next_entry.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry_out = '{valid: valid_ff, data: data_ff};

endmodule

[rtl/core/stq_chain.sv]
// Row of queue cells, head at position zero, ordered by deadline.
// Depends on stq_pkg and stq_cell.
module stq_chain
   import stq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  chain_cmd_type      cmd,
   input  entry_type          new_entry,
   input  logic [IDX_W-1:0]   probe_idx,
   output entry_type          head,
   output entry_type          probe,
   output logic [ENTRIES-1:0] valid_vec
);

   entry_type          entries [ENTRIES];
   logic [ENTRIES-1:0] ge;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_ge;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_ge    = 1'b0;
      end else begin : g_inner_left
         assign left_entry = entries[i-1];
         assign left_ge    = ge[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = entries[i+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(i)),
         .cmd         (cmd),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry_out   (entries[i]),
         .ge_out      (ge[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   assign head  = entries[0];
   assign probe = entries[probe_idx];

endmodule

[rtl/core/sorted_timeout_queue.sv]
// Channel   Direction  Handshake               Contents
// req_      in         req_valid / req_stall   operation, slot, keys, interval
// rsp_      out        rsp_valid / rsp_stall   status, slot, keys, removed, wake
// csr_      in         csr_wr_en               thread function key
//
// Tick, expire, cancel of a slot that is not queued and unknown operations go
// straight to the commit; arm first walks the slots to find a free one, and
// cancel first walks the queue positions through the chain.
// Reset clears the queue, all slot states, the tick counter and the key register.
// A request is taken while an earlier response still waits in the output register;
// its commit waits only while that register is full and stalled.
module sorted_timeout_queue
   import stq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [KEY_W-1:0]  req_key_function,
   input  logic [KEY_W-1:0]  req_key_argument,
   input  logic [TICK_W-1:0] req_interval,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_out_slot,
   output logic [KEY_W-1:0]  rsp_out_function,
   output logic [KEY_W-1:0]  rsp_out_argument,
   output logic              rsp_removed,
   output logic              rsp_wake,
   input  logic              csr_wr_en,
   input  logic [KEY_W-1:0]  csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FREE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } fsm_type;

   fsm_type            state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [KEY_W-1:0]   kf_ff, kf_in;
   logic [KEY_W-1:0]   ka_ff, ka_in;
   logic [TICK_W-1:0]  dl_ff, dl_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic [TICK_W-1:0]  now_ff, now_in;
   logic [KEY_W-1:0]   tkey_ff;
   logic [ENTRIES-1:0] set_ff, set_in;
   logic [ENTRIES-1:0] pend_ff, pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] oslot_ff, oslot_in;
   logic [KEY_W-1:0]  ofunc_ff, ofunc_in;
   logic [KEY_W-1:0]  oarg_ff, oarg_in;
   logic              removed_ff, removed_in;
   logic              wake_ff, wake_in;

   chain_cmd_type      cmd;
   entry_type          new_entry;
   entry_type          head;
   entry_type          probe;
   logic [ENTRIES-1:0] valid_vec;

   logic accept;
   logic out_free;
   logic load_rsp;
   logic scan_match;
   logic last_cnt;
   logic head_due;

   stq_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .new_entry (new_entry),
      .probe_idx (cnt_ff),
      .head      (head),
      .probe     (probe),
      .valid_vec (valid_vec)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_cnt  = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign head_due  = head.valid && (head.data.deadline <= now_ff);

   always_comb begin
      if (op_ff == OP_CANCEL_KEY) begin
         scan_match = probe.valid && (probe.data.func == kf_ff) && (probe.data.arg == ka_ff);
      end else begin
         scan_match = probe.valid && (probe.data.slot == slot_ff);
      end
   end

   // Sequencer: search phases walk one slot or one queue position per cycle.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      slot_in  = slot_ff;
      kf_in    = kf_ff;
      ka_in    = ka_ff;
      dl_in    = dl_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               slot_in = req_slot;
               kf_in   = req_key_function;
               ka_in   = req_key_argument;
               dl_in   = now_ff + req_interval;
               cnt_in  = '0;
               hit_in  = 1'b0;
               priority if (req_operation == OP_ARM) begin
                  state_in = ST_FREE;
               end else if (req_operation == OP_CANCEL_KEY) begin
                  state_in = ST_SCAN;
               end else if (req_operation == OP_CANCEL_SLOT && set_ff[req_slot]) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FREE: begin
            priority if (!set_ff[cnt_ff] && !pend_ff[cnt_ff]) begin
               hit_in   = 1'b1;
               pos_in   = cnt_ff;
               state_in = ST_FINISH;
            end else if (last_cnt) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            priority if (scan_match) begin
               hit_in   = 1'b1;
               pos_in   = cnt_ff;
               state_in = ST_FINISH;
            end else if (!probe.valid || last_cnt) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load_rsp = (state_ff == ST_FINISH) && out_free;

   // Commit: the queue, slot states and the response change together.
   always_comb begin
      now_in     = now_ff;
      set_in     = set_ff;
      pend_in    = pend_ff;
      cmd        = '0;
      new_entry  = '{valid: 1'b1,
                     data: '{slot: SLOT_W'(pos_ff), deadline: dl_ff, func: kf_ff, arg: ka_ff}};
      status_in  = STATUS_OK;
      oslot_in   = '0;
      ofunc_in   = '0;
      oarg_in    = '0;
      removed_in = 1'b0;
      wake_in    = 1'b0;
      if (load_rsp) begin
         unique case (op_ff)
            OP_TICK: begin
               now_in  = now_ff + 1'b1;
               wake_in = head.valid && (head.data.deadline <= now_in);
            end
            OP_ARM: begin
               if (hit_ff) begin
                  cmd.insert     = 1'b1;
                  set_in[pos_ff] = 1'b1;
                  oslot_in       = SLOT_W'(pos_ff);
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            OP_CANCEL_KEY: begin
               if (hit_ff) begin
                  cmd.remove               = 1'b1;
                  cmd.pos                  = pos_ff;
                  set_in[probe.data.slot]  = 1'b0;
                  oslot_in                 = probe.data.slot;
                  removed_in               = 1'b1;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            OP_CANCEL_SLOT: begin
               oslot_in = slot_ff;
               priority if (hit_ff) begin
                  cmd.remove      = 1'b1;
                  cmd.pos         = pos_ff;
                  set_in[slot_ff] = 1'b0;
                  removed_in      = 1'b1;
               end else if (pend_ff[slot_ff]) begin
                  pend_in[slot_ff] = 1'b0;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            OP_EXPIRE: begin
               if (head_due) begin
                  cmd.remove               = 1'b1;
                  cmd.pos                  = '0;
                  set_in[head.data.slot]   = 1'b0;
                  pend_in[head.data.slot]  = (head.data.func == tkey_ff);
                  oslot_in                 = head.data.slot;
                  ofunc_in                 = head.data.func;
                  oarg_in                  = head.data.arg;
                  removed_in               = 1'b1;
               end else begin
                  status_in = STATUS_NOT_DUE;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         tkey_ff      <= '0;
         set_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         set_ff       <= set_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tkey_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      slot_ff <= slot_in;
      kf_ff   <= kf_in;
      ka_ff   <= ka_in;
      dl_ff   <= dl_in;
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      if (load_rsp) begin
         status_ff  <= status_in;
         oslot_ff   <= oslot_in;
         ofunc_ff   <= ofunc_in;
         oarg_ff    <= oarg_in;
         removed_ff <= removed_in;
         wake_ff    <= wake_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_slot     = oslot_ff;
   assign rsp_out_function = ofunc_ff;
   assign rsp_out_argument = oarg_ff;
   assign rsp_removed      = removed_ff;
   assign rsp_wake         = wake_ff;

`ifndef SYNTHESIS
   // A slot is never both queued and pending.
   a_set_pend_disjoint: assert property (@(posedge clock) disable iff (reset)
      (set_ff & pend_ff) == '0)
      else $error("slot both set and pending");

   // The number of occupied cells in the chain equals the number of queued slots.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == $countones(set_ff))
      else $error("chain occupancy differs from set slots");

   // Occupied cells always form a contiguous run from the head.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((({1'b0, valid_vec}) + (ENTRIES+1)'(1)) & {1'b0, valid_vec}) == '0)
      else $error("gap in the cell chain");

   // A response is loaded only when the sequencer commits a request.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response without commit");
`endif

endmodule
